### src/hslrgb_pkg.sv
// Shared constants and types for the HSL to RGB converter.
`default_nettype none

package hslrgb_pkg;

    localparam int FRACTION_BITS = 12;
    localparam int HUE_W         = 16;
    localparam int IN_W          = 13;
    localparam int CH_W          = 8;

    localparam int ONE_W    = FRACTION_BITS + 1;
    localparam int CMP_W    = ((IN_W > ONE_W) ? IN_W : ONE_W) + 1;
    localparam int X_W      = HUE_W + 2;
    localparam int K_W      = HUE_W + 1;
    localparam int M_W      = 2 * FRACTION_BITS + 1;
    localparam int P_W      = M_W + K_W;
    localparam int LEVEL_W  = 2 * FRACTION_BITS + HUE_W + 2;
    localparam int SCALED_W = LEVEL_W + CH_W;
    localparam int SHIFT    = 2 * FRACTION_BITS + HUE_W;
    localparam int TOP_W    = SCALED_W - SHIFT;

    typedef logic [ONE_W-1:0] frac_t;
    typedef logic [K_W-1:0]   k_t;
    typedef logic [M_W-1:0]   m_t;
    typedef logic [CH_W-1:0]  chan_t;

    localparam frac_t ONE = ONE_W'(1) << FRACTION_BITS;
    localparam logic [TOP_W-1:0] CH_MAX = TOP_W'((1 << CH_W) - 1);

endpackage

`default_nettype wire

### src/hslrgb_chan.sv
// One color channel: hue ramp blend of the two levels, scale by 255, truncate.
`default_nettype none

module hslrgb_chan
    import hslrgb_pkg::*;
(
    input  wire logic  clk,
    input  wire m_t    m,
    input  wire k_t    k,
    input  wire m_t    lo,
    output chan_t      level
);

    logic [P_W-1:0]      p_reg;
    logic [LEVEL_W-1:0]  mix;
    logic [SCALED_W-1:0] scaled;
    logic [TOP_W-1:0]    top_bits;
    chan_t               level_reg;
    chan_t               level_next;

    // (hi - lo) * k, with hi - lo = 2 * m
    always_ff @(posedge clk)
    begin
        p_reg     <= P_W'(m) * P_W'(k);
        level_reg <= level_next;
    end

    always_comb
    begin
        mix        = (LEVEL_W'(lo) << HUE_W) + (LEVEL_W'(p_reg) << 1);
        scaled     = (SCALED_W'(mix) << CH_W) - SCALED_W'(mix);
        top_bits   = scaled[SCALED_W-1:SHIFT];
        level_next = (top_bits > CH_MAX) ? '1 : CH_W'(top_bits);
    end

    assign level = level_reg;

endmodule

`default_nettype wire

### src/hsl_to_rgb_top.sv
// Top level of the pipelined HSL to RGB pixel converter.
`default_nettype none

// One pixel is taken on every clock at which start is high; busy is always low.
// Each result appears on red, green and blue with done high for one cycle,
// after its start has passed a clamp and hue ramp stage, a stage
// with the saturation-lightness multiplier, a stage with one 25x17 multiplier
// per channel, and the scale-by-255 output stage. The receiver cannot stall,
// so results are never held back.
module hsl_to_rgb_top
    import hslrgb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [HUE_W-1:0]  hue,
    input  wire logic [IN_W-1:0]   saturation,
    input  wire logic [IN_W-1:0]   lightness,
    output logic                   done,
    output chan_t                  red,
    output chan_t                  green,
    output chan_t                  blue
);

    localparam logic [X_W-1:0] TURN     = X_W'(1) << HUE_W;
    localparam logic [X_W-1:0] TWO_TURN = X_W'(2) << HUE_W;
    localparam logic [X_W-1:0] TURN3    = X_W'(3) << HUE_W;

    function automatic frac_t clamp_one(input logic [IN_W-1:0] v);
        if (CMP_W'(v) > CMP_W'(ONE))
            return ONE;
        else
            return ONE_W'(v);
    endfunction

    // ramp weight of the high level, 0..TURN
    function automatic k_t ramp_k(input logic [X_W-1:0] x);
        logic [X_W:0] x2;
        x2 = {x, 1'b0};
        if (x2 < {1'b0, TURN})
            return K_W'(x2);
        else if (x2 < {1'b0, TURN3})
            return K_W'(TURN);
        else if (x < TWO_TURN)
            return K_W'({TWO_TURN - x, 1'b0});
        else
            return '0;
    endfunction

    logic [3:0] valid_reg;

    frac_t s1_reg;
    frac_t l1_reg;
    k_t    k1_reg [3];
    m_t    m2_reg;
    frac_t l2_reg;
    k_t    k2_reg [3];
    m_t    lo3_reg;

    frac_t          s1_next;
    frac_t          l1_next;
    k_t             k1_next [3];
    logic [X_W-1:0] h3;
    logic [X_W-1:0] x_red;
    logic [X_W-1:0] x_blue;
    frac_t          a_sel;
    m_t             m2_next;
    m_t             lo3_next;
    chan_t          ch_level [3];

    always_comb
    begin
        s1_next = clamp_one(saturation);
        l1_next = clamp_one(lightness);
        h3      = (X_W'(hue) << 1) + X_W'(hue);
        x_red   = h3 + TURN;
        if (x_red > TURN3)
            x_red = x_red - TURN3;
        x_blue  = (h3 < TURN) ? (h3 + TWO_TURN) : (h3 - TURN);
        k1_next[0] = ramp_k(x_red);
        k1_next[1] = ramp_k(h3);
        k1_next[2] = ramp_k(x_blue);
    end

    // m = min(l, 1-l) * s; low level = l - m, high level = l + m
    always_comb
    begin
        a_sel    = ({l1_reg, 1'b0} < {1'b0, ONE}) ? l1_reg : (ONE - l1_reg);
        m2_next  = M_W'(a_sel) * M_W'(s1_reg);
        lo3_next = (M_W'(l2_reg) << FRACTION_BITS) - m2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[2:0], start};
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= s1_next;
        l1_reg  <= l1_next;
        k1_reg  <= k1_next;
        m2_reg  <= m2_next;
        l2_reg  <= l1_reg;
        k2_reg  <= k1_reg;
        lo3_reg <= lo3_next;
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        hslrgb_chan u_chan (
            .clk   (clk),
            .m     (m2_reg),
            .k     (k2_reg[c]),
            .lo    (lo3_reg),
            .level (ch_level[c])
        );
    end

    assign busy  = 1'b0;
    assign done  = valid_reg[3];
    assign red   = ch_level[0];
    assign green = ch_level[1];
    assign blue  = ch_level[2];

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("item lost in pipeline");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without item");

    a_grey: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(saturation, 4) == '0) |-> (red == green && green == blue))
        else $error("zero saturation not grey");
`endif

endmodule

`default_nettype wire

### sim/hsl_to_rgb_top_test.sv
// Testbench for hsl_to_rgb_top: directed and random pixels checked against a built-in predictor.
module hsl_to_rgb_top_test;
    import hslrgb_pkg::*;

    localparam longint HUE_TURN   = 65536;
    localparam longint HUE_TURN3  = 3 * HUE_TURN;
    localparam int RANDOM_PIXELS  = 1900;
    localparam int SETTLE_CYCLES  = 12;
    localparam int IDLE_LIMIT     = 2000;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [IN_W-1:0]  sat;
        logic [IN_W-1:0]  light;
        logic             drain;
    } pixel_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [HUE_W-1:0]  hue = '0;
    logic [IN_W-1:0]   saturation = '0;
    logic [IN_W-1:0]   lightness = '0;
    logic              done;
    chan_t             red;
    chan_t             green;
    chan_t             blue;

    pixel_t      pixel_queue[$];
    rgb_t        rgb_expected[$];
    logic        item_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned calm_left = 0;
    int unsigned idle_cycles = 0;
    int          n_items = 0;
    int          n_grey = 0;
    int          n_clamped = 0;
    int          n_checked = 0;
    int          n_errors = 0;

    hsl_to_rgb_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Levels are scaled by unit^2, channel hue by three turns.
    function automatic chan_t ramp_level(longint unsigned lo, longint unsigned hi, longint x,
                                         longint unsigned unit);
        longint unsigned k;
        longint unsigned num;
        longint unsigned lvl;
        k = 0;
        if (x < 0)
            x += HUE_TURN3;
        if (x > HUE_TURN3)
            x -= HUE_TURN3;
        if (2 * x < HUE_TURN)
            k = 2 * x;
        else if (2 * x < HUE_TURN3)
        begin
            lvl = (hi * 255) / (unit * unit);
            return (lvl > 255) ? 8'hFF : lvl[7:0];
        end
        else if (x < 2 * HUE_TURN)
            k = 2 * (2 * HUE_TURN - x);
        num = (lo * HUE_TURN + (hi - lo) * k) * 255;
        lvl = num / (unit * unit * HUE_TURN);
        return (lvl > 255) ? 8'hFF : lvl[7:0];
    endfunction

    function automatic rgb_t predict_rgb(logic [HUE_W-1:0] h, logic [IN_W-1:0] s_in,
                                         logic [IN_W-1:0] l_in);
        longint unsigned unit;
        longint unsigned s;
        longint unsigned l;
        longint unsigned v1;
        longint unsigned v2;
        longint unsigned g;
        longint          h3;
        rgb_t            px;
        unit = 64'd1 << FRACTION_BITS;
        s = s_in;
        l = l_in;
        if (s > unit)
            s = unit;
        if (l > unit)
            l = unit;
        if (s == 0)
        begin
            g = (l * 255) / unit;
            if (g > 255)
                g = 255;
            px.red = g[7:0];
            px.green = g[7:0];
            px.blue = g[7:0];
            return px;
        end
        if (2 * l < unit)
            v2 = l * (unit + s);
        else
            v2 = (l + s) * unit - s * l;
        v1 = 2 * l * unit - v2;
        h3 = 3 * longint'(h);
        px.red = ramp_level(v1, v2, h3 + HUE_TURN, unit);
        px.green = ramp_level(v1, v2, h3, unit);
        px.blue = ramp_level(v1, v2, h3 - HUE_TURN, unit);
        return px;
    endfunction

    function automatic int unsigned next_gap();
        int unsigned roll;
        if (calm_left != 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [IN_W-1:0] rand_level(bit allow_zero);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8 && allow_zero)
            return '0;
        if (roll < 16)
            return IN_W'($urandom_range(4097, 8191));
        if (roll < 24)
        begin
            case ($urandom_range(0, 5))
                0: return IN_W'(1);
                1: return IN_W'(2047);
                2: return IN_W'(2048);
                3: return IN_W'(2049);
                4: return IN_W'(4095);
                default: return IN_W'(4096);
            endcase
        end
        return IN_W'($urandom_range(1, 4096));
    endfunction

    function automatic pixel_t rand_pixel();
        pixel_t px;
        int     sixth;
        px.drain = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            sixth = ($urandom_range(0, 6) * 65536) / 6 + $urandom_range(0, 6) - 3;
            px.hue = HUE_W'(sixth);
        end
        else
            px.hue = HUE_W'($urandom_range(0, 65535));
        px.sat = rand_level(1'b1);
        px.light = rand_level($urandom_range(0, 3) == 0);
        return px;
    endfunction

    task automatic add_pixel(int h, int s, int l, bit drain);
        pixel_t px;
        px.hue = HUE_W'(h);
        px.sat = IN_W'(s);
        px.light = IN_W'(l);
        px.drain = drain;
        pixel_queue.push_back(px);
    endtask

    task automatic check_channel(string name, chan_t want, chan_t got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // Driver: a held item stays until taken; a drain item waits for all results.
    always @(negedge clk)
    begin
        pixel_t nxt;
        if (!rst_n || (start && !item_taken))
            ;
        else if (gap_left != 0)
        begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
        end
        else if (pixel_queue.size() == 0 ||
                 (pixel_queue[0].drain && rgb_expected.size() != 0))
            start <= 1'b0;
        else
        begin
            nxt = pixel_queue.pop_front();
            hue <= nxt.hue;
            saturation <= nxt.sat;
            lightness <= nxt.light;
            start <= 1'b1;
            gap_left <= next_gap();
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        rgb_t want;
        item_taken <= start && !busy;
        if (rst_n && start && !busy)
        begin
            rgb_expected.push_back(predict_rgb(hue, saturation, lightness));
            n_items++;
            if (saturation == 0)
                n_grey++;
            if (saturation > 4096 || lightness > 4096)
                n_clamped++;
        end
        if (rst_n && done)
        begin
            if (rgb_expected.size() == 0)
            begin
                $display("%0t unexpected result: red %0d green %0d blue %0d",
                         $time, red, green, blue);
                n_errors++;
            end
            else
            begin
                want = rgb_expected.pop_front();
                check_channel("red", want.red, red);
                check_channel("green", want.green, green);
                check_channel("blue", want.blue, blue);
                n_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t timeout with %0d results outstanding", $time,
                         rgb_expected.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        add_pixel(0, 4096, 2048, 0);
        add_pixel(65535, 4096, 2048, 0);
        add_pixel(21845, 4096, 2048, 0);
        add_pixel(43690, 4096, 2048, 0);
        add_pixel(43691, 4096, 2048, 0);
        add_pixel(10922, 4096, 2048, 0);
        add_pixel(32768, 4096, 2048, 0);
        add_pixel(54613, 3000, 1500, 0);
        add_pixel(1000, 0, 0, 0);
        add_pixel(2000, 0, 4096, 0);
        add_pixel(3000, 0, 8191, 0);
        add_pixel(4000, 0, 1234, 0);
        add_pixel(65535, 8191, 8191, 1);
        add_pixel(12345, 5000, 3000, 0);
        add_pixel(23456, 4097, 4097, 0);
        add_pixel(30000, 2500, 2047, 0);
        add_pixel(30000, 2500, 2048, 0);
        add_pixel(50000, 4096, 0, 0);
        add_pixel(50000, 4096, 4096, 0);
        add_pixel(7000, 1, 2048, 0);
        add_pixel(40000, 1, 1, 0);
        add_pixel(60000, 4095, 4095, 0);
        add_pixel(0, 4096, 4096, 1);
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            pixel_queue.push_back(rand_pixel());
            if (i % 600 == 599)
                pixel_queue[$].drain = 1'b1;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pixel_queue.size() == 0);
        wait (!start);
        wait (rgb_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Converted %0d pixels: %0d grey, %0d with clamped saturation or lightness",
                 n_items, n_grey, n_clamped);
        $display("Compared %0d RGB results, %0d channel mismatches", n_checked, n_errors);
        if (n_errors == 0 && rgb_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
src/hslrgb_pkg.sv
src/hslrgb_chan.sv
src/hsl_to_rgb_top.sv
sim/hsl_to_rgb_top_test.sv
